@@ sv/gated_object_track_merge_assert.svh @@
// assertion macros shared by the gated object track merge rtl
// needs nothing but a clock, an active-low reset and the signals named in each use
`ifndef GATED_OBJECT_TRACK_MERGE_ASSERT_SVH
`define GATED_OBJECT_TRACK_MERGE_ASSERT_SVH

// condition must hold in the same cycle as the trigger
`define GOTM_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition must hold in the cycle after the trigger
`define GOTM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/gotm_pkg.sv @@
// constants, types and helper functions for the gated object track merge block
// depends on nothing; used by the top level and the testbench
`timescale 1ns / 1ps

package gotm_pkg;

    // table and field sizes
    localparam int TABLE_DEPTH = 32;
    localparam int COORD_BITS  = 24;
    localparam int TAG_BITS    = 16;
    localparam int STAMP_BITS  = 48;
    localparam int CMD_BITS    = 3;
    localparam int THR_BITS    = 16;
    localparam int GATE_BITS   = 32;

    localparam int IDX_BITS  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_BITS  = $clog2(TABLE_DEPTH + 1);
    localparam int MAG_BITS  = (COORD_BITS + 1 > THR_BITS + 1) ? COORD_BITS + 1 : THR_BITS + 1;
    localparam int DIFF_BITS = MAG_BITS + 1;
    localparam int PROD_BITS = 2 * THR_BITS;

    // configuration port
    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 32;

    localparam logic [CFG_INDEX_BITS-1:0] REG_DIST_THR  = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_TIME_GATE = CFG_INDEX_BITS'(1);

    localparam logic [THR_BITS-1:0]  DIST_THR_RESET  = THR_BITS'(2000);
    localparam logic [GATE_BITS-1:0] TIME_GATE_RESET = GATE_BITS'(300000);

    // command codes
    localparam logic [CMD_BITS-1:0] CMD_FRAME  = CMD_BITS'(0);
    localparam logic [CMD_BITS-1:0] CMD_BASE   = CMD_BITS'(1);
    localparam logic [CMD_BITS-1:0] CMD_BATCH  = CMD_BITS'(2);
    localparam logic [CMD_BITS-1:0] CMD_SOURCE = CMD_BITS'(3);
    localparam logic [CMD_BITS-1:0] CMD_EMIT   = CMD_BITS'(4);

    // one table entry
    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] z;
        logic [TAG_BITS-1:0]   tag;
    } entry_t;

    localparam int ENTRY_BITS = $bits(entry_t);

    // sign extend a coordinate to the difference width
    function automatic logic [DIFF_BITS-1:0] coord_ext(input logic [COORD_BITS-1:0] c);
        return {{(DIFF_BITS - COORD_BITS){c[COORD_BITS-1]}}, c};
    endfunction

    // floor of the average of two signed coordinates
    function automatic logic [COORD_BITS-1:0] coord_avg(input logic [COORD_BITS-1:0] a,
                                                        input logic [COORD_BITS-1:0] b);
        logic [COORD_BITS:0] s;
        s = {a[COORD_BITS-1], a} + {b[COORD_BITS-1], b};
        return s[COORD_BITS:1];
    endfunction

endpackage

@@ sv/gotm_ram.sv @@
// generic single write port, single read port ram with registered read data
// depends on nothing
`timescale 1ns / 1ps

module gotm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/gated_object_track_merge.sv @@
// gated object track merge: one multiplier shared under a small sequencer, table in gotm_ram
// frame start: decode; base object: decode, append; source batch: decode, gate check
// source object: decode, then if the gate is open per entry read, diff, squares, compare
// then merge or append; emit: per entry read, output, wait; requests are held off until done
// reset clears control, counts and flags and loads register defaults; table words stay undefined
// depends on gotm_pkg, gotm_ram and gated_object_track_merge_assert.svh
`timescale 1ns / 1ps
`include "gated_object_track_merge_assert.svh"

module gated_object_track_merge (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // item channel
    input  logic                                    item_valid,
    output logic                                    item_stall,
    input  logic [gotm_pkg::CMD_BITS-1:0]           cmd,
    input  logic [gotm_pkg::STAMP_BITS-1:0]         stamp,
    input  logic signed [gotm_pkg::COORD_BITS-1:0]  pos_x,
    input  logic signed [gotm_pkg::COORD_BITS-1:0]  pos_y,
    input  logic signed [gotm_pkg::COORD_BITS-1:0]  pos_z,
    input  logic [gotm_pkg::TAG_BITS-1:0]           object_tag,
    // result channel
    output logic                                    result_valid,
    input  logic                                    result_stall,
    output logic signed [gotm_pkg::COORD_BITS-1:0]  out_x,
    output logic signed [gotm_pkg::COORD_BITS-1:0]  out_y,
    output logic signed [gotm_pkg::COORD_BITS-1:0]  out_z,
    output logic [gotm_pkg::TAG_BITS-1:0]           out_tag,
    output logic                                    last_entry,
    output logic                                    overflowed,
    // configuration write channel
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [gotm_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [gotm_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

    import gotm_pkg::*;

    typedef enum logic [12:0] {
        ST_IDLE      = 13'b0000000000001,
        ST_DECODE    = 13'b0000000000010,
        ST_GATE      = 13'b0000000000100,
        ST_RD        = 13'b0000000001000,
        ST_DIFF      = 13'b0000000010000,
        ST_SQX       = 13'b0000000100000,
        ST_SQY       = 13'b0000001000000,
        ST_CMP       = 13'b0000010000000,
        ST_MERGE     = 13'b0000100000000,
        ST_APPEND    = 13'b0001000000000,
        ST_EMIT_RD   = 13'b0010000000000,
        ST_EMIT_OUT  = 13'b0100000000000,
        ST_EMIT_WAIT = 13'b1000000000000
    } state_t;

    // control state
    state_t                 state_reg, state_next;
    logic [IDX_BITS-1:0]    idx_reg, idx_next;
    logic [CNT_BITS-1:0]    count_reg, count_next;
    logic [STAMP_BITS-1:0]  frame_stamp_reg, frame_stamp_next;
    logic                   gate_open_reg, gate_open_next;
    logic                   source_seen_reg, source_seen_next;
    logic                   overflow_reg, overflow_next;
    logic                   result_valid_reg, result_valid_next;

    // configuration registers
    logic [THR_BITS-1:0]    dist_thr_reg;
    logic [GATE_BITS-1:0]   time_gate_reg;

    // captured request
    logic [CMD_BITS-1:0]    cmd_reg;
    logic [STAMP_BITS-1:0]  stamp_reg;
    logic [COORD_BITS-1:0]  px_reg, py_reg, pz_reg;
    logic [TAG_BITS-1:0]    tag_reg;

    // datapath registers
    logic [STAMP_BITS-1:0]  stamp_diff_reg;
    logic [PROD_BITS-1:0]   thr_sq_reg;
    logic [PROD_BITS:0]     acc_reg;
    logic [THR_BITS-1:0]    mag_x_reg, mag_y_reg;
    logic                   far_reg;
    entry_t                 entry_reg;
    logic [COORD_BITS-1:0]  out_x_reg, out_y_reg, out_z_reg;
    logic [TAG_BITS-1:0]    out_tag_reg;
    logic                   last_reg;
    logic                   overflowed_reg;

    // table ram signals
    logic                   ram_wr_en;
    logic [IDX_BITS-1:0]    ram_wr_addr;
    entry_t                 ram_wr_data;
    entry_t                 ram_rd_data;

    // combinational helpers
    logic                   item_take;
    logic                   cfg_take;
    logic [THR_BITS-1:0]    mul_a, mul_b;
    logic [PROD_BITS-1:0]   mul_p;
    logic [DIFF_BITS-1:0]   dx_full, dy_full;
    logic [DIFF_BITS-1:0]   dx_abs, dy_abs;
    logic                   far_x, far_y;
    logic                   hit;
    logic [CNT_BITS-1:0]    idx_ext;
    logic                   idx_is_last;
    logic                   table_full;
    logic                   stamp_ge;

    assign item_take   = item_valid && !item_stall;
    assign cfg_take    = cfg_valid && cfg_ready;
    assign item_stall  = (state_reg != ST_IDLE);
    assign cfg_ready   = 1'b1;
    assign idx_ext     = CNT_BITS'(idx_reg);
    assign idx_is_last = (idx_ext + CNT_BITS'(1)) == count_reg;
    assign table_full  = (count_reg == CNT_BITS'(TABLE_DEPTH));
    assign stamp_ge    = (stamp_reg >= frame_stamp_reg);

    // table storage
    gotm_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (idx_reg),
        .rd_data (ram_rd_data)
    );

    // shared multiplier: threshold square, then dx square, then dy square
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_DECODE:
            begin
                mul_a = dist_thr_reg;
                mul_b = dist_thr_reg;
            end
            ST_SQX:
            begin
                mul_a = mag_x_reg;
                mul_b = mag_x_reg;
            end
            ST_SQY:
            begin
                mul_a = mag_y_reg;
                mul_b = mag_y_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // planar differences against the entry just read
    assign dx_full = coord_ext(px_reg) - coord_ext(ram_rd_data.x);
    assign dy_full = coord_ext(py_reg) - coord_ext(ram_rd_data.y);
    assign dx_abs  = dx_full[DIFF_BITS-1] ? (~dx_full + DIFF_BITS'(1)) : dx_full;
    assign dy_abs  = dy_full[DIFF_BITS-1] ? (~dy_full + DIFF_BITS'(1)) : dy_full;
    assign far_x   = |dx_abs[MAG_BITS-1:THR_BITS];
    assign far_y   = |dy_abs[MAG_BITS-1:THR_BITS];

    // match when squared distance is strictly under squared threshold
    assign hit = !far_reg && (acc_reg < {1'b0, thr_sq_reg});

    // table write: merge averages or append the captured object
    always_comb
    begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = idx_reg;
        ram_wr_data = entry_t'{x: px_reg, y: py_reg, z: pz_reg, tag: tag_reg};
        case (state_reg)
            ST_MERGE:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = idx_reg;
                ram_wr_data = entry_t'{x:   coord_avg(entry_reg.x, px_reg),
                                       y:   coord_avg(entry_reg.y, py_reg),
                                       z:   coord_avg(entry_reg.z, pz_reg),
                                       tag: entry_reg.tag};
            end
            ST_APPEND:
            begin
                ram_wr_en   = !table_full;
                ram_wr_addr = count_reg[IDX_BITS-1:0];
            end
            default:
            begin
                ram_wr_en = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        idx_next          = idx_reg;
        count_next        = count_reg;
        frame_stamp_next  = frame_stamp_reg;
        gate_open_next    = gate_open_reg;
        source_seen_next  = source_seen_reg;
        overflow_next     = overflow_reg;
        result_valid_next = result_valid_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_take)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                idx_next = '0;
                case (cmd_reg)
                    CMD_FRAME:
                    begin
                        count_next       = '0;
                        frame_stamp_next = stamp_reg;
                        gate_open_next   = 1'b0;
                        source_seen_next = 1'b0;
                        overflow_next    = 1'b0;
                        state_next       = ST_IDLE;
                    end
                    CMD_BASE:
                    begin
                        state_next = ST_APPEND;
                    end
                    CMD_BATCH:
                    begin
                        source_seen_next = 1'b1;
                        state_next       = ST_GATE;
                    end
                    CMD_SOURCE:
                    begin
                        if (!gate_open_reg)
                        begin
                            state_next = ST_IDLE;
                        end
                        else if (count_reg == '0)
                        begin
                            state_next = ST_APPEND;
                        end
                        else
                        begin
                            state_next = ST_RD;
                        end
                    end
                    CMD_EMIT:
                    begin
                        if (source_seen_reg && (count_reg != '0))
                        begin
                            state_next = ST_EMIT_RD;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_GATE:
            begin
                gate_open_next = (stamp_diff_reg <= STAMP_BITS'(time_gate_reg));
                state_next     = ST_IDLE;
            end
            ST_RD:
            begin
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                state_next = ST_SQX;
            end
            ST_SQX:
            begin
                state_next = ST_SQY;
            end
            ST_SQY:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (hit)
                begin
                    state_next = ST_MERGE;
                end
                else if (idx_is_last)
                begin
                    state_next = ST_APPEND;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_BITS'(1);
                    state_next = ST_RD;
                end
            end
            ST_MERGE:
            begin
                state_next = ST_IDLE;
            end
            ST_APPEND:
            begin
                if (table_full)
                begin
                    overflow_next = 1'b1;
                end
                else
                begin
                    count_next = count_reg + CNT_BITS'(1);
                end
                state_next = ST_IDLE;
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_OUT;
            end
            ST_EMIT_OUT:
            begin
                result_valid_next = 1'b1;
                state_next        = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT:
            begin
                if (!result_stall)
                begin
                    result_valid_next = 1'b0;
                    if (last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_BITS'(1);
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            idx_reg          <= '0;
            count_reg        <= '0;
            frame_stamp_reg  <= '0;
            gate_open_reg    <= 1'b0;
            source_seen_reg  <= 1'b0;
            overflow_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            idx_reg          <= idx_next;
            count_reg        <= count_next;
            frame_stamp_reg  <= frame_stamp_next;
            gate_open_reg    <= gate_open_next;
            source_seen_reg  <= source_seen_next;
            overflow_reg     <= overflow_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_thr_reg  <= DIST_THR_RESET;
            time_gate_reg <= TIME_GATE_RESET;
        end
        else if (cfg_take)
        begin
            if (cfg_index == REG_DIST_THR)
            begin
                dist_thr_reg <= cfg_data[THR_BITS-1:0];
            end
            if (cfg_index == REG_TIME_GATE)
            begin
                time_gate_reg <= cfg_data[GATE_BITS-1:0];
            end
        end
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            cmd_reg   <= cmd;
            stamp_reg <= stamp;
            px_reg    <= pos_x;
            py_reg    <= pos_y;
            pz_reg    <= pos_z;
            tag_reg   <= object_tag;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DECODE)
        begin
            thr_sq_reg     <= mul_p;
            stamp_diff_reg <= stamp_ge ? (stamp_reg - frame_stamp_reg)
                                       : (frame_stamp_reg - stamp_reg);
        end
        if (state_reg == ST_DIFF)
        begin
            entry_reg <= ram_rd_data;
            mag_x_reg <= dx_abs[THR_BITS-1:0];
            mag_y_reg <= dy_abs[THR_BITS-1:0];
            far_reg   <= far_x || far_y;
        end
        if (state_reg == ST_SQX)
        begin
            acc_reg <= {1'b0, mul_p};
        end
        if (state_reg == ST_SQY)
        begin
            acc_reg <= acc_reg + {1'b0, mul_p};
        end
        if (state_reg == ST_EMIT_OUT)
        begin
            out_x_reg      <= ram_rd_data.x;
            out_y_reg      <= ram_rd_data.y;
            out_z_reg      <= ram_rd_data.z;
            out_tag_reg    <= ram_rd_data.tag;
            last_reg       <= idx_is_last;
            overflowed_reg <= overflow_reg;
        end
    end

    // result port
    assign result_valid = result_valid_reg;
    assign out_x        = out_x_reg;
    assign out_y        = out_y_reg;
    assign out_z        = out_z_reg;
    assign out_tag      = out_tag_reg;
    assign last_entry   = last_reg;
    assign overflowed   = overflowed_reg;

    // checks
    `GOTM_ASSERT_IMPLY(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_BITS'(TABLE_DEPTH), "entry count beyond table depth")
    `GOTM_ASSERT_IMPLY(a_scan_in_range, clk, rst_n, state_reg == ST_RD, idx_ext < count_reg, "scan index past entry count")
    `GOTM_ASSERT_IMPLY(a_result_in_emit, clk, rst_n, result_valid_reg, state_reg == ST_EMIT_WAIT, "result shown outside emit")
    `GOTM_ASSERT_NEXT(a_last_ends_emit, clk, rst_n, result_valid_reg && !result_stall && last_reg, state_reg == ST_IDLE, "emit run did not end on last entry")
    `GOTM_ASSERT_IMPLY(a_write_in_update, clk, rst_n, ram_wr_en, state_reg == ST_MERGE || state_reg == ST_APPEND, "table write outside merge or append")

endmodule

@@ dv/gated_object_track_merge_tb.sv @@
// self-checking testbench for gated_object_track_merge: predictor, driver, monitor, timeout
// depends on gotm_pkg and the gated_object_track_merge rtl
`timescale 1ns / 1ps

module gated_object_track_merge_tb;
    import gotm_pkg::*;

    localparam int IDLE_PCT        = 32;
    localparam int HOLD_CYCLES     = 400;
    localparam int SETTLE_CYCLES   = 200;
    localparam int ITEMS_PER_PHASE = 25;
    localparam int N_PHASES        = 5;

    // codes the block ignores
    localparam logic [CMD_BITS-1:0] CMD_SPARE_LO  = CMD_BITS'(5);
    localparam logic [CMD_BITS-1:0] CMD_SPARE_MID = CMD_BITS'(6);
    localparam logic [CMD_BITS-1:0] CMD_SPARE_HI  = CMD_BITS'(7);

    localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic [STAMP_BITS-1:0] STAMP_MAX = {STAMP_BITS{1'b1}};

    typedef struct {
        logic [CMD_BITS-1:0]          cmd;
        logic [STAMP_BITS-1:0]        stamp;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
        logic [TAG_BITS-1:0]          tag;
    } track_req_t;

    typedef struct {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
        logic [TAG_BITS-1:0]          tag;
        logic                         last;
        logic                         ovf;
    } fused_entry_t;

    logic clk;
    logic rst_n = 1'b0;

    logic                         item_valid = 1'b0;
    logic                         item_stall;
    logic [CMD_BITS-1:0]          cmd = '0;
    logic [STAMP_BITS-1:0]        stamp = '0;
    logic signed [COORD_BITS-1:0] pos_x = '0;
    logic signed [COORD_BITS-1:0] pos_y = '0;
    logic signed [COORD_BITS-1:0] pos_z = '0;
    logic [TAG_BITS-1:0]          object_tag = '0;

    logic                         result_valid;
    logic                         result_stall = 1'b0;
    logic signed [COORD_BITS-1:0] out_x;
    logic signed [COORD_BITS-1:0] out_y;
    logic signed [COORD_BITS-1:0] out_z;
    logic [TAG_BITS-1:0]          out_tag;
    logic                         last_entry;
    logic                         overflowed;

    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [CFG_INDEX_BITS-1:0]    cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]     cfg_data = '0;

    // predicted block state and registers
    logic signed [COORD_BITS-1:0] tbl_x [TABLE_DEPTH];
    logic signed [COORD_BITS-1:0] tbl_y [TABLE_DEPTH];
    logic signed [COORD_BITS-1:0] tbl_z [TABLE_DEPTH];
    logic [TAG_BITS-1:0]          tbl_tag [TABLE_DEPTH];
    int                           tbl_count = 0;
    logic [STAMP_BITS-1:0]        frame_base = '0;
    bit                           gate_is_open = 1'b0;
    bit                           batch_seen = 1'b0;
    bit                           drop_seen = 1'b0;
    logic [THR_BITS-1:0]          dist_thr = DIST_THR_RESET;
    logic [GATE_BITS-1:0]         gate_window = TIME_GATE_RESET;

    track_req_t   request_backlog[$];
    fused_entry_t fused_entry_q[$];
    track_req_t   drive_req;
    fused_entry_t got_want;

    int  items_queued = 0;
    int  items_taken = 0;
    int  results_checked = 0;
    int  frames_started = 0;
    int  merges_done = 0;
    int  objects_dropped = 0;
    int  fail_count = 0;
    bit  steady = 1'b0;
    bit  hold_arm = 1'b0;
    bit  hold_taken = 1'b0;
    int  hold_left = 0;

    gated_object_track_merge dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .cmd          (cmd),
        .stamp        (stamp),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .object_tag   (object_tag),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_x        (out_x),
        .out_y        (out_y),
        .out_z        (out_z),
        .out_tag      (out_tag),
        .last_entry   (last_entry),
        .overflowed   (overflowed),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // floor of the mean of two coordinates
    function automatic logic signed [COORD_BITS-1:0] half_sum(
        input logic signed [COORD_BITS-1:0] a,
        input logic signed [COORD_BITS-1:0] b);
        longint s;
        s = longint'(a) + longint'(b);
        return COORD_BITS'(s >>> 1);
    endfunction

    // add an object to the table, or note the drop when full
    function automatic void table_append(input track_req_t req);
        if (tbl_count >= TABLE_DEPTH)
        begin
            drop_seen = 1'b1;
            objects_dropped++;
        end
        else
        begin
            tbl_x[tbl_count]   = req.x;
            tbl_y[tbl_count]   = req.y;
            tbl_z[tbl_count]   = req.z;
            tbl_tag[tbl_count] = req.tag;
            tbl_count++;
        end
    endfunction

    // update predicted state for one accepted request, queue the entries it emits
    function automatic void merge_track_item(input track_req_t req);
        logic [STAMP_BITS-1:0] gap;
        longint dx;
        longint dy;
        longint thr;
        bit hit;
        int i;
        fused_entry_t ent;
        hit = 1'b0;
        case (req.cmd)
            CMD_FRAME:
            begin
                tbl_count    = 0;
                frame_base   = req.stamp;
                gate_is_open = 1'b0;
                batch_seen   = 1'b0;
                drop_seen    = 1'b0;
                frames_started++;
            end
            CMD_BASE: table_append(req);
            CMD_BATCH:
            begin
                gap = (req.stamp >= frame_base) ? req.stamp - frame_base : frame_base - req.stamp;
                batch_seen   = 1'b1;
                gate_is_open = (gap <= gate_window);
            end
            CMD_SOURCE:
            begin
                if (gate_is_open)
                begin
                    thr = longint'(dist_thr);
                    // first entry in table order within the planar radius wins
                    for (i = 0; i < tbl_count && !hit; i++)
                    begin
                        dx = longint'(req.x) - longint'(tbl_x[i]);
                        dy = longint'(req.y) - longint'(tbl_y[i]);
                        if (dx < 0) dx = -dx;
                        if (dy < 0) dy = -dy;
                        if (dx <= 65535 && dy <= 65535 && dx * dx + dy * dy < thr * thr)
                        begin
                            hit = 1'b1;
                            tbl_x[i] = half_sum(tbl_x[i], req.x);
                            tbl_y[i] = half_sum(tbl_y[i], req.y);
                            tbl_z[i] = half_sum(tbl_z[i], req.z);
                            merges_done++;
                        end
                    end
                    if (!hit) table_append(req);
                end
            end
            CMD_EMIT:
            begin
                if (batch_seen)
                begin
                    for (i = 0; i < tbl_count; i++)
                    begin
                        ent.x    = tbl_x[i];
                        ent.y    = tbl_y[i];
                        ent.z    = tbl_z[i];
                        ent.tag  = tbl_tag[i];
                        ent.last = (i == tbl_count - 1);
                        ent.ovf  = drop_seen;
                        fused_entry_q.insert(fused_entry_q.size(), ent);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void push_item(input logic [CMD_BITS-1:0] c,
                                      input logic [STAMP_BITS-1:0] s,
                                      input longint x, input longint y, input longint z,
                                      input longint tag);
        track_req_t r;
        r.cmd   = c;
        r.stamp = s;
        r.x     = COORD_BITS'(x);
        r.y     = COORD_BITS'(y);
        r.z     = COORD_BITS'(z);
        r.tag   = TAG_BITS'(tag);
        request_backlog.insert(request_backlog.size(), r);
        items_queued++;
    endfunction

    function automatic longint any_coord();
        logic signed [COORD_BITS-1:0] v;
        v = COORD_BITS'($urandom);
        return v;
    endfunction

    function automatic logic [STAMP_BITS-1:0] any_stamp();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[STAMP_BITS-1:0];
    endfunction

    // coordinate around a center, or anywhere when spread is negative
    function automatic longint near(input longint c, input int spread);
        if (spread < 0) return any_coord();
        return c + longint'($urandom_range(0, 2 * spread)) - spread;
    endfunction

    function automatic void check_field(input string name,
                                        input logic signed [63:0] want_v,
                                        input logic signed [63:0] got_v);
        if (want_v !== got_v)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
            fail_count++;
        end
    endfunction

    // one frame: base objects, gated source batches, then mostly an emit; or a single stray request
    task automatic queue_random_frame();
        logic [STAMP_BITS-1:0] fs;
        longint off;
        longint cx;
        longint cy;
        longint cz;
        int spread;
        int n_base;
        int n_batch;
        int n_src;
        int b;
        int k;
        if ($urandom_range(0, 11) == 0)
        begin
            // stray request with arbitrary code and fields
            push_item(CMD_BITS'($urandom_range(0, 7)), any_stamp(), any_coord(), any_coord(),
                      any_coord(), $urandom);
            return;
        end
        case ($urandom_range(0, 4))
            0: spread = 300;
            1: spread = 1500;
            2: spread = 5000;
            3: spread = 40000;
            default: spread = -1;
        endcase
        cx = longint'($urandom_range(0, 8000000)) - 4000000;
        cy = longint'($urandom_range(0, 8000000)) - 4000000;
        cz = longint'($urandom_range(0, 8000000)) - 4000000;
        fs = any_stamp();
        push_item(CMD_FRAME, fs, any_coord(), any_coord(), any_coord(), $urandom);
        n_base = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 34) : $urandom_range(0, 6);
        for (k = 0; k < n_base; k++)
            push_item(CMD_BASE, any_stamp(), near(cx, spread), near(cy, spread),
                      near(cz, spread), $urandom);
        n_batch = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 2);
        for (b = 0; b < n_batch; b++)
        begin
            if ($urandom_range(0, 4) == 0)
                off = longint'(gate_window) + 1 + $urandom_range(0, 5000);
            else
                off = longint'($urandom_range(0, gate_window));
            push_item(CMD_BATCH,
                      STAMP_BITS'(($urandom_range(0, 1) != 0) ? fs + off : fs - off),
                      any_coord(), any_coord(), any_coord(), $urandom);
            n_src = $urandom_range(0, 5);
            for (k = 0; k < n_src; k++)
                push_item(CMD_SOURCE, any_stamp(), near(cx, spread), near(cy, spread),
                          near(cz, spread), $urandom);
        end
        if ($urandom_range(0, 9) != 0)
            push_item(CMD_EMIT, any_stamp(), any_coord(), any_coord(), any_coord(), $urandom);
        if ($urandom_range(0, 5) == 0)
            push_item(CMD_EMIT, any_stamp(), any_coord(), any_coord(), any_coord(), $urandom);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_DIST_THR)
            dist_thr = val[THR_BITS-1:0];
        else if (idx == REG_TIME_GATE)
            gate_window = val;
    endtask

    // all requests taken, all entries seen, then room for a trailing table scan
    task automatic wait_quiet();
        do @(posedge clk); while (items_taken != items_queued || fused_entry_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                merge_track_item(drive_req);
                items_taken++;
            end
            if (!item_valid || !item_stall)
            begin
                if (request_backlog.size() != 0 &&
                    (steady || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    drive_req = request_backlog.pop_front();
                    item_valid <= 1'b1;
                    cmd        <= drive_req.cmd;
                    stamp      <= drive_req.stamp;
                    pos_x      <= drive_req.x;
                    pos_y      <= drive_req.y;
                    pos_z      <= drive_req.z;
                    object_tag <= drive_req.tag;
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // result stall, with one long hold so the block backs up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left    <= hold_left - 1;
            result_stall <= 1'b1;
        end
        else if (hold_arm && !hold_taken && result_valid)
        begin
            hold_left    <= HOLD_CYCLES;
            hold_taken   <= 1'b1;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (fused_entry_q.size() == 0)
            begin
                $error("entry with nothing expected: x %0d y %0d tag %0d", out_x, out_y, out_tag);
                fail_count++;
            end
            else
            begin
                got_want = fused_entry_q.pop_front();
                check_field("out_x", got_want.x, out_x);
                check_field("out_y", got_want.y, out_y);
                check_field("out_z", got_want.z, out_z);
                check_field("out_tag", got_want.tag, out_tag);
                check_field("last_entry", got_want.last, last_entry);
                check_field("overflowed", got_want.ovf, overflowed);
                results_checked++;
            end
        end
    end

    // stimulus and phases
    initial
    begin
        int ph;
        int target;
        logic [THR_BITS-1:0]  thr_set;
        logic [GATE_BITS-1:0] gate_set;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed, at reset register values
        push_item(CMD_BATCH, 100, 0, 0, 0, 0);                      // batch before any frame
        push_item(CMD_SOURCE, 0, COORD_MAX, COORD_MAX, COORD_MAX, 16'hFFFF);
        push_item(CMD_EMIT, 0, 0, 0, 0, 0);
        push_item(CMD_EMIT, STAMP_MAX, 0, 0, 0, 0);                  // repeated emit
        push_item(CMD_SPARE_HI, STAMP_MAX, COORD_MIN, COORD_MAX, -1, 16'hFFFF);
        push_item(CMD_FRAME, STAMP_MAX, 0, 0, 0, 0);
        push_item(CMD_BASE, 0, COORD_MIN, COORD_MIN, COORD_MIN, 0);
        push_item(CMD_BASE, 0, 0, 0, 0, 16'h1234);
        push_item(CMD_EMIT, 0, 0, 0, 0, 0);                          // no batch yet
        push_item(CMD_BATCH, 0, 0, 0, 0, 0);                         // far outside the gate
        push_item(CMD_SOURCE, 0, 0, 0, 0, 16'h5555);                 // ignored, gate closed
        push_item(CMD_EMIT, 0, 0, 0, 0, 0);
        push_item(CMD_BATCH, STAMP_MAX - TIME_GATE_RESET, 0, 0, 0, 0); // exactly on the gate
        push_item(CMD_SOURCE, 0, 1999, 0, 7, 16'hAAAA);              // just inside the radius
        push_item(CMD_SOURCE, 0, -1001, 0, -5, 16'h0F0F);            // exactly on the radius
        push_item(CMD_SOURCE, 0, -1000, 1, -3, 16'hF0F0);            // negative floor average
        push_item(CMD_EMIT, 0, 0, 0, 0, 0);
        push_item(CMD_FRAME, 0, 0, 0, 0, 0);
        push_item(CMD_BATCH, TIME_GATE_RESET + 1, 0, 0, 0, 0);       // one past the gate
        push_item(CMD_EMIT, 0, 0, 0, 0, 0);                          // empty table
        push_item(CMD_SPARE_LO, 0, 0, 0, 0, 0);
        push_item(CMD_SPARE_MID, STAMP_MAX, -1, -1, -1, 16'hFFFF);
        wait_quiet();

        // random frames over several register settings
        for (ph = 0; ph < N_PHASES; ph++)
        begin
            steady   <= (ph == 1);
            hold_arm <= (ph >= 2);
            case (ph)
                0:
                begin
                    thr_set  = 1500;
                    gate_set = 250000;
                end
                1:
                begin
                    thr_set  = 0;
                    gate_set = 0;
                end
                2:
                begin
                    thr_set  = 16'hFFFF;
                    gate_set = 32'hFFFFFFFF;
                end
                3:
                begin
                    thr_set  = THR_BITS'($urandom_range(100, 9000));
                    gate_set = $urandom;
                end
                default:
                begin
                    thr_set  = DIST_THR_RESET;
                    gate_set = TIME_GATE_RESET;
                end
            endcase
            write_reg(REG_DIST_THR, {THR_BITS'($urandom), thr_set});
            write_reg(REG_TIME_GATE, gate_set);
            target = items_queued + ITEMS_PER_PHASE;
            while (items_queued < target)
                queue_random_frame();
            wait_quiet();
        end

        $display("ran %0d requests over %0d frames and %0d register settings; %0d entries checked",
                 items_taken, frames_started, N_PHASES, results_checked);
        $display("predicted %0d merges and %0d dropped objects", merges_done, objects_dropped);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // timeout
    initial
    begin
        #8_000_000;
        $display("timeout: %0d of %0d requests taken, %0d entries outstanding",
                 items_taken, items_queued, fused_entry_q.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
